// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the filter RTL; clk and rst_n are taken from the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- hdl/fldc_pkg.sv -----
// Shared types, constants and the coefficient lookup of the low-pass filter with DC offset.
`default_nettype none

package fldc_pkg;

  // Coefficient format: Q1.15, signed
  localparam int COEF_W    = 16;
  localparam int COEF_FRAC = 15;
  localparam int HALF_TAPS = 22;
  localparam int HIDX_W    = $clog2(HALF_TAPS);

  // Millivolt scale 1000/1240 reduced to lowest terms
  localparam int MV_SCALE_MUL = 25;
  localparam int MV_SCALE_DIV = 31;

  // Half of the symmetric impulse response, outer tap first
  localparam logic signed [COEF_W-1:0] HALF_COEF [HALF_TAPS] = '{
    -16'sd279,  -16'sd90,   16'sd245,   16'sd578,   16'sd543,  16'sd86,
    -16'sd367,  -16'sd308,  16'sd253,   16'sd677,   16'sd356,  -16'sd501,
    -16'sd929,  -16'sd236,  16'sd1014,  16'sd1338,  -16'sd75,  -16'sd2075,
    -16'sd2159, 16'sd1239,  16'sd6870,  16'sd11208
  };

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_ACC,
    ST_POST,
    ST_DIV_BLK,
    ST_MV,
    ST_DIV_MV,
    ST_OUT
  } fldc_state_t;

  // Controls from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic clr;
    logic mul;
    logic add;
  } fldc_mac_ctrl_t;

  // Tap k folds onto the half table; entries past it are zero
  function automatic logic signed [COEF_W-1:0] fldc_coef(input int k, input int taps);
    int m;
    int h;
    logic signed [COEF_W-1:0] c;
    m = taps - 1 - k;
    h = (k < m) ? k : m;
    if (h < 0 || h >= HALF_TAPS) begin
      c = '0;
    end else begin
      c = HALF_COEF[h[HIDX_W-1:0]];
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/fldc_tap_cell.sv -----
// One delay-line cell: holds a sample and takes its neighbour's value when enabled.
`default_nettype none

module fldc_tap_cell #(
  parameter int W = 12
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         en,
  input  wire logic [W-1:0] d,
  output logic      [W-1:0] q
);

  logic [W-1:0] q_r;

  // Clear at reset, advance on enable
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else if (en) begin
      q_r <= d;
    end
  end

  assign q = q_r;

endmodule

`default_nettype wire

// ----- hdl/fldc_mac.sv -----
// Shared multiply-accumulate unit with coefficient lookup and output saturation.
`default_nettype none

module fldc_mac #(
  parameter int TAPS        = 44,
  parameter int SAMPLE_BITS = 12
) (
  input  wire logic                             clk,
  input  wire fldc_pkg::fldc_mac_ctrl_t         ctrl,
  input  wire logic [$clog2(TAPS)-1:0]          step,
  input  wire logic [SAMPLE_BITS-1:0]           x,
  output logic      [SAMPLE_BITS-1:0]           filt
);

  import fldc_pkg::*;

  localparam int STEP_W = $clog2(TAPS);
  localparam int PROD_W = COEF_W + SAMPLE_BITS + 1;
  localparam int ACC_W  = PROD_W + STEP_W + 1;

  logic signed [COEF_W-1:0] coef;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;

  // Coefficient of the tap now at the end of the ring
  assign coef = fldc_coef(int'(step), TAPS);

  // Multiply into the product register, add the previous product
  always_comb begin
    prod_nxt = prod_r;
    acc_nxt  = acc_r;
    if (ctrl.clr) begin
      prod_nxt = '0;
      acc_nxt  = '0;
    end else begin
      if (ctrl.mul) begin
        prod_nxt = coef * $signed({1'b0, x});
      end
      if (ctrl.add) begin
        acc_nxt = acc_r + ACC_W'(prod_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
  end

  // Floor by 2^15 and clamp to the sample range
  always_comb begin
    if (acc_r[ACC_W-1]) begin
      filt = '0;
    end else if (|acc_r[ACC_W-2:COEF_FRAC+SAMPLE_BITS]) begin
      filt = '1;
    end else begin
      filt = acc_r[COEF_FRAC+SAMPLE_BITS-1:COEF_FRAC];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/fldc_serdiv.sv -----
// Division by one of two fixed divisors through reciprocal multiplication, with a registered result.
`default_nettype none
`include "assert_macros.svh"

module fldc_serdiv #(
  parameter int DW = 19,
  parameter int D0 = 100,
  parameter int D1 = 31
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic          sel,
  input  wire logic [DW-1:0] dividend,
  output logic               done,
  output logic      [DW-1:0] quotient
);

  // floor(n / d) equals (n * ceil(2^s / d)) >> s for every n below 2^DW when s = DW + clog2(d)
  localparam int     S0 = DW + $clog2(D0);
  localparam int     S1 = DW + $clog2(D1);
  localparam int     MW = DW + 1;
  localparam int     PW = DW + MW;
  localparam longint R0 = ((longint'(1) << S0) + longint'(D0) - 1) / longint'(D0);
  localparam longint R1 = ((longint'(1) << S1) + longint'(D1) - 1) / longint'(D1);
  localparam logic [MW-1:0] RCP0 = MW'(R0);
  localparam logic [MW-1:0] RCP1 = MW'(R1);

  logic          done_r, done_nxt;
  logic          sel_r, sel_nxt;
  logic [PW-1:0] prod_r, prod_nxt;

  // Multiply by the reciprocal of the chosen divisor
  always_comb begin
    done_nxt = start;
    sel_nxt  = sel_r;
    prod_nxt = prod_r;
    if (start) begin
      sel_nxt  = sel;
      prod_nxt = PW'(dividend) * PW'(sel ? RCP1 : RCP0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= done_nxt;
    end
    sel_r  <= sel_nxt;
    prod_r <= prod_nxt;
  end

  // Drop the fraction bits of the product
  assign done     = done_r;
  assign quotient = sel_r ? DW'(prod_r >> S1) : DW'(prod_r >> S0);

  `ASSERT_NXT(a_start_done, start, done_r)
  `ASSERT_NXT(a_idle_quiet, !start, !done_r)

endmodule

`default_nettype wire

// ----- hdl/fir_lowpass_with_dc_offset.sv -----
// Top level: symmetric low-pass FIR on a ring of tap cells, block-mean offset, millivolt capture.
//
//  channel | direction | tdata (low bit up)                                  | tuser
//  in_     | slave     | sample                                              | cmd
//  out_    | master    | filtered, mv_value, capture_count, dc_offset        | mv_valid
//
// After its transfer a sample passes the accept state, one step per tap through the shared
// multiply-accumulate, a step for the last product, then block sum, millivolt scale, scale
// result and output load before the next ready. Past the capture limit the scale result step
// is skipped, on closing a block a step for the mean comes in; a restart stays idle and ready.
// Reset is synchronous and clears the delay line and the block and capture counters.
// A waiting result holds in the output register; the next sample runs and only its load waits.
`default_nettype none
`include "assert_macros.svh"

module fir_lowpass_with_dc_offset #(
  parameter int TAPS        = 44,
  parameter int BLOCK_LEN   = 100,
  parameter int SAMPLE_BITS = 12
) (
  input  wire logic clk,
  input  wire logic rst_n,
  // sample
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0] in_tdata,
  // cmd
  input  wire logic                             in_tuser,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // filtered, mv_value, capture_count, dc_offset
  output logic [((3*SAMPLE_BITS+1+$clog2(BLOCK_LEN+1)+7)/8)*8-1:0] out_tdata,
  // mv_valid
  output logic                                  out_tuser,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready
);

  import fldc_pkg::*;

  localparam int SB          = SAMPLE_BITS;
  localparam int STEP_W      = $clog2(TAPS);
  localparam int CNT_W       = $clog2(BLOCK_LEN + 1);
  localparam int SUM_W       = SB + CNT_W;
  localparam int MVD_W       = SB + 5;
  localparam int DIV_W       = (SUM_W > MVD_W) ? SUM_W : MVD_W;
  localparam int OUT_W       = 3 * SB + 1 + CNT_W;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  localparam logic [CNT_W-1:0]  BLK_LEN_C = CNT_W'(BLOCK_LEN);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(TAPS - 1);

  // Sequencer and bookkeeping registers
  fldc_state_t        state_r, state_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [SB-1:0]      y_r, y_nxt;
  logic [CNT_W-1:0]   blk_cnt_r, blk_cnt_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [SB-1:0]      offset_r, offset_nxt;
  logic [CNT_W-1:0]   cap_r, cap_nxt;
  logic               neg_r, neg_nxt;
  logic signed [SB:0] mv_r, mv_nxt;
  logic               mv_vld_r, mv_vld_nxt;

  // Output register
  logic               out_vld_r, out_vld_nxt;
  logic [SB-1:0]      out_filt_r, out_filt_nxt;
  logic [SB:0]        out_mv_r, out_mv_nxt;
  logic [CNT_W-1:0]   out_cnt_r, out_cnt_nxt;
  logic [SB-1:0]      out_off_r, out_off_nxt;
  logic               out_user_r, out_user_nxt;

  // Datapath nets
  logic               in_xfer;
  logic               cell_load, cell_rot;
  logic [SB-1:0]      tap_q [TAPS];
  fldc_mac_ctrl_t     mac_ctrl;
  logic [SB-1:0]      filt;
  logic signed [SB:0] diff;
  logic [SB-1:0]      mag;
  logic [MVD_W-1:0]   mvd;
  logic               div_start, div_sel, div_done;
  logic [DIV_W-1:0]   div_dividend, div_quo;

  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;

  // Ring of tap cells: shift in on a new sample, rotate once per tap
  for (genvar j = 0; j < TAPS; j++) begin : g_cell
    logic [SB-1:0] d;
    if (j == 0) begin : g_head
      assign d = cell_load ? in_tdata[SB-1:0] : tap_q[TAPS-1];
    end else begin : g_body
      assign d = tap_q[j-1];
    end
    fldc_tap_cell #(.W(SB)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (cell_load || cell_rot),
      .d     (d),
      .q     (tap_q[j])
    );
  end

  fldc_mac #(.TAPS(TAPS), .SAMPLE_BITS(SB)) u_mac (
    .clk  (clk),
    .ctrl (mac_ctrl),
    .step (step_r),
    .x    (tap_q[TAPS-1]),
    .filt (filt)
  );

  fldc_serdiv #(.DW(DIV_W), .D0(BLOCK_LEN), .D1(MV_SCALE_DIV)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .sel      (div_sel),
    .dividend (div_dividend),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Offset-removed value and its scaled magnitude
  assign diff = $signed({1'b0, y_r}) - $signed({1'b0, offset_r});
  assign mag  = diff[SB] ? SB'(-diff) : diff[SB-1:0];
  assign mvd  = MVD_W'(mag) * MVD_W'(MV_SCALE_MUL);

  // Next state and datapath control
  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    y_nxt        = y_r;
    blk_cnt_nxt  = blk_cnt_r;
    sum_nxt      = sum_r;
    offset_nxt   = offset_r;
    cap_nxt      = cap_r;
    neg_nxt      = neg_r;
    mv_nxt       = mv_r;
    mv_vld_nxt   = mv_vld_r;
    out_vld_nxt  = out_vld_r && !out_tready;
    out_filt_nxt = out_filt_r;
    out_mv_nxt   = out_mv_r;
    out_cnt_nxt  = out_cnt_r;
    out_off_nxt  = out_off_r;
    out_user_nxt = out_user_r;
    cell_load    = 1'b0;
    cell_rot     = 1'b0;
    mac_ctrl     = '0;
    div_start    = 1'b0;
    div_sel      = 1'b0;
    div_dividend = DIV_W'(sum_r);

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_tuser) begin
            // Restart: clear the capture count only
            cap_nxt = '0;
          end else begin
            cell_load    = 1'b1;
            mac_ctrl.clr = 1'b1;
            step_nxt     = '0;
            state_nxt    = ST_MAC;
          end
        end
      end
      ST_MAC: begin
        cell_rot     = 1'b1;
        mac_ctrl.mul = 1'b1;
        mac_ctrl.add = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        // Add the last product
        mac_ctrl.add = 1'b1;
        state_nxt    = ST_POST;
      end
      ST_POST: begin
        y_nxt = filt;
        if (blk_cnt_r < BLK_LEN_C) begin
          sum_nxt     = sum_r + SUM_W'(filt);
          blk_cnt_nxt = blk_cnt_r + 1'b1;
          state_nxt   = ST_MV;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIV_BLK;
        end
      end
      ST_DIV_BLK: begin
        // Block closed: take the mean, start a new block
        if (div_done) begin
          offset_nxt  = div_quo[SB-1:0];
          blk_cnt_nxt = '0;
          sum_nxt     = '0;
          state_nxt   = ST_MV;
        end
      end
      ST_MV: begin
        if (cap_r < BLK_LEN_C) begin
          neg_nxt      = diff[SB];
          div_start    = 1'b1;
          div_sel      = 1'b1;
          div_dividend = DIV_W'(mvd);
          state_nxt    = ST_DIV_MV;
        end else begin
          mv_nxt     = '0;
          mv_vld_nxt = 1'b0;
          state_nxt  = ST_OUT;
        end
      end
      ST_DIV_MV: begin
        // Truncate toward zero: scale the magnitude, then restore the sign
        if (div_done) begin
          mv_nxt     = neg_r ? -$signed({1'b0, div_quo[SB-1:0]})
                             : $signed({1'b0, div_quo[SB-1:0]});
          mv_vld_nxt = 1'b1;
          cap_nxt    = cap_r + 1'b1;
          state_nxt  = ST_OUT;
        end
      end
      ST_OUT: begin
        // Load the output register once the previous transfer has gone
        if (!out_vld_r || out_tready) begin
          out_vld_nxt  = 1'b1;
          out_filt_nxt = y_r;
          out_mv_nxt   = mv_r;
          out_cnt_nxt  = cap_r;
          out_off_nxt  = offset_r;
          out_user_nxt = mv_vld_r;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_vld_r <= 1'b0;
      blk_cnt_r <= '0;
      sum_r     <= '0;
      offset_r  <= '0;
      cap_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
      blk_cnt_r <= blk_cnt_nxt;
      sum_r     <= sum_nxt;
      offset_r  <= offset_nxt;
      cap_r     <= cap_nxt;
    end
    step_r     <= step_nxt;
    y_r        <= y_nxt;
    neg_r      <= neg_nxt;
    mv_r       <= mv_nxt;
    mv_vld_r   <= mv_vld_nxt;
    out_filt_r <= out_filt_nxt;
    out_mv_r   <= out_mv_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_off_r  <= out_off_nxt;
    out_user_r <= out_user_nxt;
  end

  // Pack the result fields, filtered value in the low bits
  assign out_tdata  = OUT_TDATA_W'({out_off_r, out_cnt_r, out_mv_r, out_filt_r});
  assign out_tuser  = out_user_r;
  assign out_tvalid = out_vld_r;

  `ASSERT_IMP(a_cap_bound, 1'b1, cap_r <= BLK_LEN_C && blk_cnt_r <= BLK_LEN_C)
  `ASSERT_IMP(a_div_wait, state_r == ST_DIV_BLK || state_r == ST_DIV_MV, div_done)
  `ASSERT_IMP(a_mv_count, out_vld_r && out_user_r, out_cnt_r != '0)
  `ASSERT_NXT(a_mac_run, state_r == ST_MAC && step_r != LAST_STEP, state_r == ST_MAC)

endmodule

`default_nettype wire
